@@ rtl/pip_pkg.sv @@
// Shared types and constants for the point-in-polygon test block.
// No dependencies; every other file imports this package.
package pip_pkg;

  // Default coordinate width in bits
  localparam int COORD_WIDTH_DEF = 24;

  // Item command codes
  typedef enum logic [0:0] {
    CMD_BEGIN  = 1'b0,
    CMD_VERTEX = 1'b1
  } cmd_t;

  // Axis dropped by the projection
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Per-edge compare results known before the multiplies
  typedef struct packed {
    logic va;       // start above query in v
    logic vb;       // end above query in v
    logic ua;       // start right of query in u
    logic ub;       // end right of query in u
    logic hit_end;  // query equals an endpoint
    logic degen;    // start equals end
  } edge_flags_t;

  // Per-edge flags carried with the products
  typedef struct packed {
    edge_flags_t f;
    logic        between;  // query strictly between endpoints on the leading axis
    logic        dv_pos;
    logic        dv_neg;
  } edge_mid_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic is_begin;
    logic last;
    logic close_border;
    logic border_mode;
    logic normal_zero;
  } job_ctl_t;

endpackage

@@ rtl/pip_edge_prep.sv @@
// Edge setup: coordinate differences, projected crossing operands and endpoint compares.
// Depends on pip_pkg.
module pip_edge_prep #(
  parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  pip_pkg::axis_t              axis,
  input  logic signed [COORD_WIDTH-1:0] s_pt [0:2],
  input  logic signed [COORD_WIDTH-1:0] e_pt [0:2],
  input  logic signed [COORD_WIDTH-1:0] q_pt [0:2],
  output logic signed [COORD_WIDTH:0]   ev [0:2],
  output logic signed [COORD_WIDTH:0]   tv [0:2],
  output logic signed [COORD_WIDTH:0]   cu,
  output logic signed [COORD_WIDTH:0]   dv,
  output logic signed [COORD_WIDTH:0]   cv,
  output logic signed [COORD_WIDTH:0]   du,
  output pip_pkg::edge_flags_t        flags
);
  import pip_pkg::*;

  localparam int D = COORD_WIDTH + 1;

  logic [1:0] u_idx;
  logic [1:0] v_idx;

  // Projection axes: the two axes left after dropping one
  always_comb begin
    case (axis)
      AXIS_X: begin
        u_idx = 2'd1;
        v_idx = 2'd2;
      end
      AXIS_Y: begin
        u_idx = 2'd0;
        v_idx = 2'd2;
      end
      default: begin
        u_idx = 2'd0;
        v_idx = 2'd1;
      end
    endcase
  end

  // Edge vector and query offset from the start point
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ev[k] = D'(e_pt[k]) - D'(s_pt[k]);
      tv[k] = D'(q_pt[k]) - D'(s_pt[k]);
    end
  end

  // Crossing operands in the projected plane
  assign cu = D'(e_pt[u_idx]) - D'(q_pt[u_idx]);
  assign dv = D'(s_pt[v_idx]) - D'(e_pt[v_idx]);
  assign cv = D'(e_pt[v_idx]) - D'(q_pt[v_idx]);
  assign du = D'(s_pt[u_idx]) - D'(e_pt[u_idx]);

  // Side and equality compares
  always_comb begin
    flags.va      = s_pt[v_idx] > q_pt[v_idx];
    flags.vb      = e_pt[v_idx] > q_pt[v_idx];
    flags.ua      = s_pt[u_idx] > q_pt[u_idx];
    flags.ub      = e_pt[u_idx] > q_pt[u_idx];
    flags.hit_end = ((s_pt[0] == q_pt[0]) && (s_pt[1] == q_pt[1]) && (s_pt[2] == q_pt[2])) ||
                    ((e_pt[0] == q_pt[0]) && (e_pt[1] == q_pt[1]) && (e_pt[2] == q_pt[2]));
    flags.degen   = (s_pt[0] == e_pt[0]) && (s_pt[1] == e_pt[1]) && (s_pt[2] == e_pt[2]);
  end

endmodule

@@ rtl/pip_edge_mul.sv @@
// Edge multiply stage: crossing products, collinearity cross products, range check.
// Depends on pip_pkg.
module pip_edge_mul #(
  parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [COORD_WIDTH:0]       ev [0:2],
  input  logic signed [COORD_WIDTH:0]       tv [0:2],
  input  logic signed [COORD_WIDTH:0]       cu,
  input  logic signed [COORD_WIDTH:0]       dv,
  input  logic signed [COORD_WIDTH:0]       cv,
  input  logic signed [COORD_WIDTH:0]       du,
  input  pip_pkg::edge_flags_t            flags,
  output logic signed [2*COORD_WIDTH+1:0]   cr_lhs,
  output logic signed [2*COORD_WIDTH+1:0]   cr_rhs,
  output logic signed [2*COORD_WIDTH+1:0]   xp_lhs [0:2],
  output logic signed [2*COORD_WIDTH+1:0]   xp_rhs [0:2],
  output pip_pkg::edge_mid_t              mid
);
  import pip_pkg::*;

  localparam int D = COORD_WIDTH + 1;
  localparam int P = 2 * COORD_WIDTH + 2;

  logic signed [D-1:0] ev_k;
  logic signed [D-1:0] tv_k;
  logic                between;

  // Crossing test products
  assign cr_lhs = P'(cu) * P'(dv);
  assign cr_rhs = P'(cv) * P'(du);

  // Cross product terms of edge vector and query offset
  assign xp_lhs[0] = P'(ev[1]) * P'(tv[2]);
  assign xp_rhs[0] = P'(ev[2]) * P'(tv[1]);
  assign xp_lhs[1] = P'(ev[2]) * P'(tv[0]);
  assign xp_rhs[1] = P'(ev[0]) * P'(tv[2]);
  assign xp_lhs[2] = P'(ev[0]) * P'(tv[1]);
  assign xp_rhs[2] = P'(ev[1]) * P'(tv[0]);

  // Range check on the first axis where the edge has extent
  always_comb begin
    if (ev[0] != '0) begin
      ev_k = ev[0];
      tv_k = tv[0];
    end else if (ev[1] != '0) begin
      ev_k = ev[1];
      tv_k = tv[1];
    end else begin
      ev_k = ev[2];
      tv_k = tv[2];
    end
    if (ev_k > 0) begin
      between = (tv_k > 0) && (tv_k < ev_k);
    end else begin
      between = (tv_k < 0) && (tv_k > ev_k);
    end
  end

  always_comb begin
    mid.f       = flags;
    mid.between = between;
    mid.dv_neg  = dv[D-1];
    mid.dv_pos  = !dv[D-1] && (dv != '0);
  end

endmodule

@@ rtl/pip_edge_eval.sv @@
// Edge decision: crossing parity toggle and on-edge hit from registered products.
// Depends on pip_pkg.
module pip_edge_eval #(
  parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic signed [2*COORD_WIDTH+1:0] cr_lhs,
  input  logic signed [2*COORD_WIDTH+1:0] cr_rhs,
  input  logic signed [2*COORD_WIDTH+1:0] xp_lhs [0:2],
  input  logic signed [2*COORD_WIDTH+1:0] xp_rhs [0:2],
  input  pip_pkg::edge_mid_t            mid,
  output logic                          toggle,
  output logic                          hit
);
  import pip_pkg::*;

  logic gt;
  logic lt;
  logic collinear;

  assign gt = cr_lhs > cr_rhs;
  assign lt = cr_lhs < cr_rhs;

  // Ray crossing: edge straddles the query in v and passes on the +u side
  always_comb begin
    if (mid.f.va == mid.f.vb) begin
      toggle = 1'b0;
    end else if (mid.f.ua == mid.f.ub) begin
      toggle = mid.f.ua;
    end else begin
      toggle = (mid.dv_pos && gt) || (mid.dv_neg && lt);
    end
  end

  // Border: endpoint match, or collinear and strictly inside the segment
  assign collinear = (xp_lhs[0] == xp_rhs[0]) && (xp_lhs[1] == xp_rhs[1]) &&
                     (xp_lhs[2] == xp_rhs[2]);
  assign hit = mid.f.hit_end || (!mid.f.degen && collinear && mid.between);

endmodule

@@ rtl/point_in_polygon_3d_test_unit.sv @@
// Crossing-number point-in-polygon test for a planar polygon in 3D space.
// Top level; depends on pip_pkg, pip_edge_prep, pip_edge_mul, pip_edge_eval.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one item per transfer. A begin
//   item (in_command = 0) loads the query point, plane normal and the
//   with-border and closed flags. Vertex items (in_command = 1) follow; the one
//   with in_last_vertex set produces one result on the output channel
//   (out_valid/out_ready): out_inside_res and out_on_border.
//   Each vertex item evaluates its incoming edge and, when last, the closing
//   edge, in a three-register pipeline: setup register, product register,
//   then parity/border accumulate into the output register. A result is
//   presented once the last vertex has passed through all three registers;
//   one item is accepted every cycle while no result waits on the receiver.
//   When the receiver stalls, items without a result keep draining into the
//   accumulators; only an item carrying a result waits, and in_ready drops once
//   the pipeline registers behind it are full.
//   Reset clears the pipeline and sets query point to the origin, normal to
//   zero (result outside) and both modes off.
module point_in_polygon_3d_test_unit #(
  parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_command,
  input  logic [COORD_WIDTH-1:0] in_coord_x,
  input  logic [COORD_WIDTH-1:0] in_coord_y,
  input  logic [COORD_WIDTH-1:0] in_coord_z,
  input  logic [COORD_WIDTH-1:0] in_normal_x,
  input  logic [COORD_WIDTH-1:0] in_normal_y,
  input  logic [COORD_WIDTH-1:0] in_normal_z,
  input  logic                   in_with_border,
  input  logic                   in_is_closed,
  input  logic                   in_last_vertex,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_inside_res,
  output logic                   out_on_border
);
  import pip_pkg::*;

  localparam int W         = COORD_WIDTH;
  localparam int D         = COORD_WIDTH + 1;
  localparam int P         = 2 * COORD_WIDTH + 2;
  localparam int NUM_EDGES = 2;

  // ---------------------------------------------------------------- front state
  logic signed [W-1:0] pt [0:2];
  logic signed [W-1:0] query_r [0:2];
  logic signed [W-1:0] query_nxt [0:2];
  logic signed [W-1:0] prev_r [0:2];
  logic signed [W-1:0] prev_nxt [0:2];
  logic signed [W-1:0] first_r [0:2];
  logic signed [W-1:0] first_nxt [0:2];
  axis_t               axis_r, axis_nxt, axis_sel;
  logic                nz_r, nz_nxt;
  logic                bm_r, bm_nxt;
  logic                cm_r, cm_nxt;
  logic                seen_r, seen_nxt;
  logic [W-1:0]        mag_x, mag_y, mag_z;
  logic                accept;
  logic                is_begin;

  // ---------------------------------------------------------------- pipeline
  logic signed [W-1:0] s_vec [0:NUM_EDGES-1][0:2];
  logic signed [W-1:0] e_vec [0:NUM_EDGES-1][0:2];

  logic signed [D-1:0] p_ev [0:NUM_EDGES-1][0:2];
  logic signed [D-1:0] p_tv [0:NUM_EDGES-1][0:2];
  logic signed [D-1:0] p_cu [0:NUM_EDGES-1];
  logic signed [D-1:0] p_dv [0:NUM_EDGES-1];
  logic signed [D-1:0] p_cv [0:NUM_EDGES-1];
  logic signed [D-1:0] p_du [0:NUM_EDGES-1];
  edge_flags_t         p_flags [0:NUM_EDGES-1];
  job_ctl_t            job_ctl;

  logic signed [D-1:0] a_ev_r [0:NUM_EDGES-1][0:2];
  logic signed [D-1:0] a_tv_r [0:NUM_EDGES-1][0:2];
  logic signed [D-1:0] a_cu_r [0:NUM_EDGES-1];
  logic signed [D-1:0] a_dv_r [0:NUM_EDGES-1];
  logic signed [D-1:0] a_cv_r [0:NUM_EDGES-1];
  logic signed [D-1:0] a_du_r [0:NUM_EDGES-1];
  edge_flags_t         a_flags_r [0:NUM_EDGES-1];
  job_ctl_t            a_ctl_r;
  logic                a_valid_r, a_valid_nxt;

  logic signed [P-1:0] m_cr_lhs [0:NUM_EDGES-1];
  logic signed [P-1:0] m_cr_rhs [0:NUM_EDGES-1];
  logic signed [P-1:0] m_xp_lhs [0:NUM_EDGES-1][0:2];
  logic signed [P-1:0] m_xp_rhs [0:NUM_EDGES-1][0:2];
  edge_mid_t           m_mid [0:NUM_EDGES-1];

  logic signed [P-1:0] b_cr_lhs_r [0:NUM_EDGES-1];
  logic signed [P-1:0] b_cr_rhs_r [0:NUM_EDGES-1];
  logic signed [P-1:0] b_xp_lhs_r [0:NUM_EDGES-1][0:2];
  logic signed [P-1:0] b_xp_rhs_r [0:NUM_EDGES-1][0:2];
  edge_mid_t           b_mid_r [0:NUM_EDGES-1];
  job_ctl_t            b_ctl_r;
  logic                b_valid_r, b_valid_nxt;

  logic                e_toggle [0:NUM_EDGES-1];
  logic                e_hit [0:NUM_EDGES-1];

  logic                a_go, a_free, b_go, b_free, res_job;

  // ---------------------------------------------------------------- accumulate / output
  logic parity_r, parity_nxt;
  logic border_r, border_nxt;
  logic par_sum, bord_sum;
  logic out_valid_r, out_valid_nxt;
  logic out_inside_r, out_on_border_r;

  assign pt[0] = $signed(in_coord_x);
  assign pt[1] = $signed(in_coord_y);
  assign pt[2] = $signed(in_coord_z);

  assign accept   = in_valid && in_ready;
  assign is_begin = (in_command == CMD_BEGIN);

  // Dominant normal axis; ties fall to Z
  assign mag_x = in_normal_x[W-1] ? (~in_normal_x + W'(1)) : in_normal_x;
  assign mag_y = in_normal_y[W-1] ? (~in_normal_y + W'(1)) : in_normal_y;
  assign mag_z = in_normal_z[W-1] ? (~in_normal_z + W'(1)) : in_normal_z;

  always_comb begin
    if ((mag_x > mag_y) && (mag_x > mag_z)) begin
      axis_sel = AXIS_X;
    end else if ((mag_y > mag_x) && (mag_y > mag_z)) begin
      axis_sel = AXIS_Y;
    end else begin
      axis_sel = AXIS_Z;
    end
  end

  // Front state update on each input transfer
  always_comb begin
    query_nxt = query_r;
    prev_nxt  = prev_r;
    first_nxt = first_r;
    axis_nxt  = axis_r;
    nz_nxt    = nz_r;
    bm_nxt    = bm_r;
    cm_nxt    = cm_r;
    seen_nxt  = seen_r;
    if (accept) begin
      if (is_begin) begin
        query_nxt = pt;
        axis_nxt  = axis_sel;
        nz_nxt    = (in_normal_x == '0) && (in_normal_y == '0) && (in_normal_z == '0);
        bm_nxt    = in_with_border;
        cm_nxt    = in_is_closed;
        seen_nxt  = 1'b0;
      end else begin
        prev_nxt = pt;
        if (!seen_r) begin
          first_nxt = pt;
        end
        seen_nxt = !in_last_vertex;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        query_r[k] <= '0;
      end
      axis_r <= AXIS_X;
      nz_r   <= 1'b1;
      bm_r   <= 1'b0;
      cm_r   <= 1'b0;
      seen_r <= 1'b0;
    end else begin
      query_r <= query_nxt;
      axis_r  <= axis_nxt;
      nz_r    <= nz_nxt;
      bm_r    <= bm_nxt;
      cm_r    <= cm_nxt;
      seen_r  <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r  <= prev_nxt;
    first_r <= first_nxt;
  end

  // Edge endpoints: incoming edge (degenerate on the first vertex) and closing edge
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_vec[0][k] = seen_r ? prev_r[k] : pt[k];
      e_vec[0][k] = pt[k];
      s_vec[1][k] = pt[k];
      e_vec[1][k] = seen_r ? first_r[k] : pt[k];
    end
  end

  always_comb begin
    job_ctl.is_begin     = is_begin;
    job_ctl.last         = !is_begin && in_last_vertex;
    job_ctl.close_border = cm_r;
    job_ctl.border_mode  = bm_r;
    job_ctl.normal_zero  = nz_r;
  end

  // Per-edge datapath
  for (genvar g = 0; g < NUM_EDGES; g++) begin : g_edges
    pip_edge_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
      .axis  (axis_r),
      .s_pt  (s_vec[g]),
      .e_pt  (e_vec[g]),
      .q_pt  (query_r),
      .ev    (p_ev[g]),
      .tv    (p_tv[g]),
      .cu    (p_cu[g]),
      .dv    (p_dv[g]),
      .cv    (p_cv[g]),
      .du    (p_du[g]),
      .flags (p_flags[g])
    );

    pip_edge_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
      .ev     (a_ev_r[g]),
      .tv     (a_tv_r[g]),
      .cu     (a_cu_r[g]),
      .dv     (a_dv_r[g]),
      .cv     (a_cv_r[g]),
      .du     (a_du_r[g]),
      .flags  (a_flags_r[g]),
      .cr_lhs (m_cr_lhs[g]),
      .cr_rhs (m_cr_rhs[g]),
      .xp_lhs (m_xp_lhs[g]),
      .xp_rhs (m_xp_rhs[g]),
      .mid    (m_mid[g])
    );

    pip_edge_eval #(.COORD_WIDTH(COORD_WIDTH)) u_eval (
      .cr_lhs (b_cr_lhs_r[g]),
      .cr_rhs (b_cr_rhs_r[g]),
      .xp_lhs (b_xp_lhs_r[g]),
      .xp_rhs (b_xp_rhs_r[g]),
      .mid    (b_mid_r[g]),
      .toggle (e_toggle[g]),
      .hit    (e_hit[g])
    );
  end

  // Pipeline flow: only an item with a result waits on the output register
  assign res_job  = b_ctl_r.last;
  assign b_go     = b_valid_r && (!res_job || !out_valid_r || out_ready);
  assign b_free   = !b_valid_r || b_go;
  assign a_go     = a_valid_r && b_free;
  assign a_free   = !a_valid_r || a_go;
  assign in_ready = a_free;

  always_comb begin
    a_valid_nxt = accept ? 1'b1 : (a_go ? 1'b0 : a_valid_r);
    b_valid_nxt = a_go ? 1'b1 : (b_go ? 1'b0 : b_valid_r);
  end

  // Setup and product registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_ev_r    <= p_ev;
      a_tv_r    <= p_tv;
      a_cu_r    <= p_cu;
      a_dv_r    <= p_dv;
      a_cv_r    <= p_cv;
      a_du_r    <= p_du;
      a_flags_r <= p_flags;
      a_ctl_r   <= job_ctl;
    end
    if (a_go) begin
      b_cr_lhs_r <= m_cr_lhs;
      b_cr_rhs_r <= m_cr_rhs;
      b_xp_lhs_r <= m_xp_lhs;
      b_xp_rhs_r <= m_xp_rhs;
      b_mid_r    <= m_mid;
      b_ctl_r    <= a_ctl_r;
    end
  end

  // Parity and border accumulation; closing edge counts only on the last vertex
  assign par_sum  = parity_r ^ e_toggle[0] ^ (b_ctl_r.last & e_toggle[1]);
  assign bord_sum = border_r | e_hit[0] | (b_ctl_r.last & b_ctl_r.close_border & e_hit[1]);

  always_comb begin
    parity_nxt    = parity_r;
    border_nxt    = border_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (b_go) begin
      if (b_ctl_r.is_begin || b_ctl_r.last) begin
        parity_nxt = 1'b0;
        border_nxt = 1'b0;
      end else begin
        parity_nxt = par_sum;
        border_nxt = bord_sum;
      end
      if (res_job) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      parity_r    <= 1'b0;
      border_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      parity_r    <= parity_nxt;
      border_r    <= border_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (b_go && res_job) begin
      out_on_border_r <= b_ctl_r.border_mode && bord_sum;
      out_inside_r    <= (b_ctl_r.border_mode && bord_sum) ||
                         (!b_ctl_r.normal_zero && par_sum);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_on_border  = out_on_border_r;

endmodule

@@ sim/pip_check_pkg.sv @@
// Item and verdict types plus the scoreboard for the point-in-polygon testbench.
// Depends on pip_pkg (command and axis enums, coordinate width).
package pip_check_pkg;
  import pip_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;

  typedef longint vec3_t [3];

  // One input transfer, as driven on the in_ ports
  typedef struct {
    cmd_t           cmd;
    logic [CW-1:0]  x, y, z;
    logic [CW-1:0]  nx, ny, nz;
    logic           with_border;
    logic           closed;
    logic           last;
  } pip_item_t;

  // One result transfer
  typedef struct packed {
    logic in_poly;
    logic border;
  } pip_verdict_t;

  // Tracks the polygon under test and queues the verdict each polygon ending in a last vertex should give
  class pip_verdict_board;
    vec3_t        query = '{0, 0, 0};
    vec3_t        first_v = '{0, 0, 0};
    vec3_t        prev_v = '{0, 0, 0};
    axis_t        drop_axis = AXIS_X;
    bit           normal_is_zero = 1'b1;
    bit           parity = 1'b0;
    bit           border_hit = 1'b0;
    bit           border_mode = 1'b0;
    bit           closed_mode = 1'b0;
    int unsigned  vertex_cnt = 0;
    pip_verdict_t verdict_q[$];
    int unsigned  errors = 0;
    int unsigned  n_begin = 0;
    int unsigned  n_vertex = 0;
    int unsigned  n_checked = 0;
    int unsigned  n_border = 0;
    int unsigned  n_in_poly = 0;

    function longint sext(logic [CW-1:0] v);
      longint r;
      r = $signed(v);
      return r;
    endfunction

    // sign of a*b - c*d; operands stay below 2^26, so 64 bits hold it exactly
    function int cross_sign(longint a, longint b, longint c, longint d);
      longint t;
      t = a * b - c * d;
      if (t > 0) return 1;
      if (t < 0) return -1;
      return 0;
    endfunction

    function bit same_pt(vec3_t a, vec3_t b);
      return a[0] == b[0] && a[1] == b[1] && a[2] == b[2];
    endfunction

    // query on segment s-e: an endpoint, or collinear and strictly between
    function bit on_edge(vec3_t s, vec3_t e);
      vec3_t ev, tv;
      int    k;
      if (same_pt(query, s) || same_pt(query, e)) return 1'b1;
      if (same_pt(s, e)) return 1'b0;
      for (k = 0; k < 3; k++) begin
        ev[k] = e[k] - s[k];
        tv[k] = query[k] - s[k];
      end
      if (cross_sign(ev[1], tv[2], ev[2], tv[1]) != 0 ||
          cross_sign(ev[2], tv[0], ev[0], tv[2]) != 0 ||
          cross_sign(ev[0], tv[1], ev[1], tv[0]) != 0)
        return 1'b0;
      k = (ev[0] != 0) ? 0 : ((ev[1] != 0) ? 1 : 2);
      if (ev[k] > 0) return tv[k] > 0 && tv[k] < ev[k];
      return tv[k] < 0 && tv[k] > ev[k];
    endfunction

    // toggle parity when edge p-c crosses the +u ray from the query
    function void edge_crossing(vec3_t p, vec3_t c);
      int     u, v, r;
      bit     va, vb, ua, ub;
      longint d;
      u = (drop_axis == AXIS_X) ? 1 : 0;
      v = (drop_axis == AXIS_Z) ? 1 : 2;
      va = p[v] > query[v];
      vb = c[v] > query[v];
      if (va == vb) return;
      ua = p[u] > query[u];
      ub = c[u] > query[u];
      if (ua == ub) begin
        if (ua) parity ^= 1'b1;
      end else begin
        d = p[v] - c[v];
        r = cross_sign(c[u] - query[u], d, c[v] - query[v], p[u] - c[u]);
        if ((d > 0 && r > 0) || (d < 0 && r < 0)) parity ^= 1'b1;
      end
    endfunction

    // update polygon state with an accepted input transfer
    function void take_item(pip_item_t it);
      vec3_t        pt;
      longint       nx, ny, nz, ax, ay, az;
      pip_verdict_t vd;
      pt[0] = sext(it.x);
      pt[1] = sext(it.y);
      pt[2] = sext(it.z);
      if (it.cmd == CMD_BEGIN) begin
        nx = sext(it.nx);
        ny = sext(it.ny);
        nz = sext(it.nz);
        ax = (nx < 0) ? -nx : nx;
        ay = (ny < 0) ? -ny : ny;
        az = (nz < 0) ? -nz : nz;
        query = pt;
        normal_is_zero = (nx == 0 && ny == 0 && nz == 0);
        // strict dominance, ties fall to Z
        if (ax > ay && ax > az) drop_axis = AXIS_X;
        else if (ay > ax && ay > az) drop_axis = AXIS_Y;
        else drop_axis = AXIS_Z;
        border_mode = it.with_border;
        closed_mode = it.closed;
        parity = 1'b0;
        border_hit = 1'b0;
        vertex_cnt = 0;
        n_begin++;
        return;
      end
      n_vertex++;
      if (vertex_cnt == 0) begin
        first_v = pt;
        if (same_pt(query, pt)) border_hit = 1'b1;
      end else begin
        edge_crossing(prev_v, pt);
        if (on_edge(prev_v, pt)) border_hit = 1'b1;
      end
      prev_v = pt;
      if (vertex_cnt < 2) vertex_cnt++;
      if (!it.last) return;
      // closing edge always counts for parity, for border only when closed
      edge_crossing(prev_v, first_v);
      if (closed_mode && vertex_cnt >= 2 && on_edge(prev_v, first_v)) border_hit = 1'b1;
      vd.border = border_mode && border_hit;
      vd.in_poly = vd.border || (!normal_is_zero && parity);
      verdict_q.push_back(vd);
      parity = 1'b0;
      border_hit = 1'b0;
      vertex_cnt = 0;
    endfunction

    // compare a result transfer with the oldest queued verdict
    function void check_verdict(logic in_poly, logic border);
      pip_verdict_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, in_poly %0b border %0b", $time, in_poly, border);
        return;
      end
      want = verdict_q.pop_front();
      n_checked++;
      if (want.border) n_border++;
      if (want.in_poly) n_in_poly++;
      if (in_poly !== want.in_poly) begin
        errors++;
        $display("%0t: out_inside_res expected %0b actual %0b", $time, want.in_poly, in_poly);
      end
      if (border !== want.border) begin
        errors++;
        $display("%0t: out_on_border expected %0b actual %0b", $time, want.border, border);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

endpackage

@@ sim/point_in_polygon_3d_test_unit_test.sv @@
// Testbench for point_in_polygon_3d_test_unit: directed and random polygons, random idling.
// Depends on pip_pkg, pip_check_pkg and the RTL of the block.
module point_in_polygon_3d_test_unit_test;
  import pip_pkg::*;
  import pip_check_pkg::*;

  localparam int ITEM_TARGET  = 1750;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int VMAX         = 8;
  localparam int CMAX         = (1 << (CW - 1)) - 1;
  localparam int CMIN         = -(1 << (CW - 1));

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_command = 1'b0;
  logic [CW-1:0] in_coord_x = '0;
  logic [CW-1:0] in_coord_y = '0;
  logic [CW-1:0] in_coord_z = '0;
  logic [CW-1:0] in_normal_x = '0;
  logic [CW-1:0] in_normal_y = '0;
  logic [CW-1:0] in_normal_z = '0;
  logic          in_with_border = 1'b0;
  logic          in_is_closed = 1'b0;
  logic          in_last_vertex = 1'b0;
  logic          out_ready = 1'b0;
  logic          in_ready;
  logic          out_valid;
  logic          out_inside_res;
  logic          out_on_border;

  pip_verdict_board board = new();
  int unsigned      items_sent = 0;
  int unsigned      stall_cnt = 0;
  int unsigned      held_cycles = 0;
  int unsigned      poly = 0;
  bit               hold_req = 1'b0;
  bit               no_idle = 1'b0;

  point_in_polygon_3d_test_unit #(
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .in_normal_x   (in_normal_x),
    .in_normal_y   (in_normal_y),
    .in_normal_z   (in_normal_z),
    .in_with_border(in_with_border),
    .in_is_closed  (in_is_closed),
    .in_last_vertex(in_last_vertex),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_inside_res(out_inside_res),
    .out_on_border (out_on_border)
  );

  // 4-unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result check and stall watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_verdict(out_inside_res, out_on_border);
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cnt);
      $display("point_in_polygon_3d_test_unit_test: FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // receiver: random backpressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          held_cycles++;
        end
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // offer one item, with an optional gap first, and wait for its transfer
  task automatic send(pip_item_t it);
    if (!no_idle && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= it.cmd;
    in_coord_x     <= it.x;
    in_coord_y     <= it.y;
    in_coord_z     <= it.z;
    in_normal_x    <= it.nx;
    in_normal_y    <= it.ny;
    in_normal_z    <= it.nz;
    in_with_border <= it.with_border;
    in_is_closed   <= it.closed;
    in_last_vertex <= it.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_item(it);
    items_sent++;
  endtask

  task automatic put(cmd_t c, int x, int y, int z, int nx, int ny, int nz,
                     bit wb, bit cl, bit lst);
    pip_item_t it;
    it.cmd = c;
    it.x = x[CW-1:0];
    it.y = y[CW-1:0];
    it.z = z[CW-1:0];
    it.nx = nx[CW-1:0];
    it.ny = ny[CW-1:0];
    it.nz = nz[CW-1:0];
    it.with_border = wb;
    it.closed = cl;
    it.last = lst;
    send(it);
  endtask

  // coordinate in a narrow, moderate or full span
  function automatic int rnd_coord(int span);
    int r;
    case (span)
      0: r = $urandom_range(0, 12) - 6;
      1: r = $urandom_range(0, 2000) - 1000;
      default: begin
        r = $urandom;
        r = r >>> (32 - CW);
        if ($urandom_range(0, 7) == 0) r = $urandom_range(0, 1) ? CMAX : CMIN;
      end
    endcase
    return r;
  endfunction

  // fully random item: any command, any bits
  task automatic send_noise();
    pip_item_t it;
    it.cmd = cmd_t'($urandom_range(0, 1));
    it.x = CW'($urandom);
    it.y = CW'($urandom);
    it.z = CW'($urandom);
    it.nx = CW'($urandom);
    it.ny = CW'($urandom);
    it.nz = CW'($urandom);
    it.with_border = 1'($urandom_range(0, 1));
    it.closed = 1'($urandom_range(0, 1));
    it.last = 1'($urandom_range(0, 1));
    send(it);
  endtask

  // begin item plus a vertex run; query often placed on a vertex or an edge
  task automatic run_polygon();
    int span, nv, i, j, sel, a, rounds, rnd, lim;
    int vx[VMAX], vy[VMAX], vz[VMAX];
    int qx, qy, qz, dx, dy, dz, nx, ny, nz;
    bit wb, cl, cut;
    sel = $urandom_range(0, 9);
    span = (sel < 6) ? 0 : ((sel < 9) ? 1 : 2);
    // plane normal: mostly random, sometimes zero or with tied magnitudes
    sel = $urandom_range(0, 9);
    a = $urandom_range(1, 9);
    if (sel == 0) begin
      nx = 0; ny = 0; nz = 0;
    end else if (sel == 1) begin
      nx = a;
      ny = $urandom_range(0, 1) ? a : -a;
      nz = $urandom_range(0, a);
    end else if (sel == 2) begin
      nx = $urandom_range(0, a - 1);
      ny = -a;
      nz = a;
    end else begin
      nx = rnd_coord($urandom_range(0, 2));
      ny = rnd_coord($urandom_range(0, 2));
      nz = rnd_coord($urandom_range(0, 2));
    end
    wb = ($urandom_range(0, 9) < 7);
    cl = 1'($urandom_range(0, 1));
    nv = ($urandom_range(0, 3) != 0) ? $urandom_range(3, 6) : $urandom_range(1, VMAX);
    for (i = 0; i < nv; i++) begin
      vx[i] = rnd_coord(span);
      vy[i] = rnd_coord(span);
      vz[i] = rnd_coord(span);
    end
    qx = rnd_coord(span);
    qy = rnd_coord(span);
    qz = rnd_coord(span);
    sel = $urandom_range(0, 3);
    if (sel == 1) begin
      i = $urandom_range(0, nv - 1);
      qx = vx[i]; qy = vy[i]; qz = vz[i];
    end else if (sel == 2 && span < 2 && nv >= 2) begin
      // stretch one edge so its midpoint is exact, closing edge included
      i = $urandom_range(0, nv - 1);
      j = (i + 1) % nv;
      dx = rnd_coord(0); dy = rnd_coord(0); dz = rnd_coord(0);
      vx[j] = vx[i] + 2 * dx; vy[j] = vy[i] + 2 * dy; vz[j] = vz[i] + 2 * dz;
      qx = vx[i] + dx; qy = vy[i] + dy; qz = vz[i] + dz;
    end
    cut = ($urandom_range(0, 19) == 0);
    rounds = ($urandom_range(0, 9) == 0) ? 2 : 1;
    lim = cut ? nv - 1 : nv;
    put(CMD_BEGIN, qx, qy, qz, nx, ny, nz, wb, cl, 1'($urandom_range(0, 1)));
    // a second round reuses the query after the first result
    for (rnd = 0; rnd < rounds; rnd++) begin
      for (i = 0; i < lim; i++) begin
        put(CMD_VERTEX, vx[i], vy[i], vz[i], $urandom, $urandom, $urandom,
            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), !cut && i == nv - 1);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // vertex before any begin: origin query, zero normal, modes off
    put(CMD_VERTEX, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    // zero normal, border on: single vertex on the query; last flag on begin ignored
    put(CMD_BEGIN, 0, 0, 0, 0, 0, 0, 1, 1, 1);
    put(CMD_VERTEX, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    // square around the query, Z dropped, border off
    put(CMD_BEGIN, 1, 1, 0, 0, 0, 5, 0, 1, 0);
    put(CMD_VERTEX, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    put(CMD_VERTEX, 4, 0, 0, 0, 0, 0, 0, 0, 0);
    put(CMD_VERTEX, 4, 4, 0, 0, 0, 0, 0, 0, 0);
    put(CMD_VERTEX, 0, 4, 0, 0, 0, 0, 0, 0, 1);
    // X and Y tie drops Z; open polygon with query on the skipped closing edge
    put(CMD_BEGIN, 2, 2, 0, 5, -5, 1, 1, 0, 0);
    put(CMD_VERTEX, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    put(CMD_VERTEX, 4, 0, 0, 0, 0, 0, 0, 0, 0);
    put(CMD_VERTEX, 4, 4, 0, 0, 0, 0, 0, 0, 1);
    // X dropped; begin in mid-polygon restarts, then a full-range square
    put(CMD_BEGIN, 0, 0, 0, -7, 3, 3, 1, 1, 0);
    put(CMD_VERTEX, 0, CMIN, CMIN, 0, 0, 0, 0, 0, 0);
    put(CMD_BEGIN, 0, 0, 0, -7, 3, 3, 1, 1, 0);
    put(CMD_VERTEX, 0, CMIN, CMIN, 0, 0, 0, 0, 0, 0);
    put(CMD_VERTEX, 0, CMAX, CMIN, 0, 0, 0, 0, 0, 0);
    put(CMD_VERTEX, 0, CMAX, CMAX, 0, 0, 0, 0, 0, 0);
    put(CMD_VERTEX, 0, CMIN, CMAX, 0, 0, 0, 0, 0, 1);
    // Y dropped; degenerate edge, then query strictly inside the next edge
    put(CMD_BEGIN, 3, 0, 3, 1, -9, 2, 1, 1, 0);
    put(CMD_VERTEX, 1, 0, 1, 0, 0, 0, 0, 0, 0);
    put(CMD_VERTEX, 1, 0, 1, 0, 0, 0, 0, 0, 0);
    put(CMD_VERTEX, 5, 0, 5, 0, 0, 0, 0, 0, 1);
    // extreme query and normal, X/Z magnitude tie
    put(CMD_BEGIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0, 0, 1);
    put(CMD_VERTEX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 1, 1, 1);

    // random polygons with some noise; one long receiver hold-off, one idle-free stretch
    while (items_sent < ITEM_TARGET) begin
      if (poly == 40) hold_req = 1'b1;
      no_idle = (poly >= 120 && poly < 170);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_noise();
      end else begin
        run_polygon();
      end
      poly++;
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items in %0d groups: %0d begins, %0d vertices; %0d results checked.",
             items_sent, poly, board.n_begin, board.n_vertex, board.n_checked);
    $display("Results on border %0d, inside %0d; receiver held off for %0d cycles.",
             board.n_border, board.n_in_poly, held_cycles);
    if (board.errors == 0) begin
      $display("point_in_polygon_3d_test_unit_test: PASS");
    end else begin
      $display("point_in_polygon_3d_test_unit_test: FAIL");
    end
    $finish;
  end

endmodule

@@ point_in_polygon_3d_test_unit.f @@
rtl/pip_pkg.sv
rtl/pip_edge_prep.sv
rtl/pip_edge_mul.sv
rtl/pip_edge_eval.sv
rtl/point_in_polygon_3d_test_unit.sv
sim/pip_check_pkg.sv
sim/point_in_polygon_3d_test_unit_test.sv
